// ===== src/http_status_line_parser_top_defines.svh =====
// Assertion macros used by the parse core of the status line parser.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef HTTP_STATUS_LINE_PARSER_TOP_DEFINES_SVH
`define HTTP_STATUS_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HSLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HSLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hslp_pkg.sv =====
// Shared types, codes and constants of the HTTP status line parser.
// No dependencies; the stage modules and the top module import this package.
package hslp_pkg;

  // Parsing phase within one line.
  typedef enum logic [1:0] {
    PH_VERSION = 2'd0,
    PH_CODE    = 2'd1,
    PH_REASON  = 2'd2
  } phase_t;

  // Error kinds reported on the final byte.
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_CONTROL = 3'd1;
  localparam logic [2:0] ERR_NOSPACE = 3'd2;
  localparam logic [2:0] ERR_VERSION = 3'd3;
  localparam logic [2:0] ERR_CODE    = 3'd4;

  // Character constants.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Token lengths.
  localparam logic [3:0] VER_PREFIX_LEN = 4'd5;
  localparam logic [3:0] VER_LEN        = 4'd8;
  localparam logic [3:0] VER_POS_MAX    = 4'd15;
  localparam logic [2:0] CODE_LEN       = 3'd3;
  localparam logic [2:0] CODE_CNT_MAX   = 3'd7;

  // One input item.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       reason_valid;
    logic [7:0] reason_byte;
    logic       done_res;
    logic [2:0] error_kind;
    logic [9:0] status_code;
    logic [3:0] version_major;
    logic [3:0] version_minor;
  } result_t;

  // Expected byte of the "HTTP/" version prefix at a given position.
  function automatic logic [7:0] ver_prefix(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      default: ch = 8'h2f;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

// ===== src/hslp_in_if.sv =====
// Input channel of the status line parser: valid/ready plus one line byte and its end flag.
// Depends on nothing.
interface hslp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_end;

  modport source (output valid, output line_byte, output line_end, input ready);
  modport sink (input valid, input line_byte, input line_end, output ready);
endinterface

// ===== src/hslp_out_if.sv =====
// Result channel of the status line parser: valid/ready plus the result fields.
// Depends on nothing.
interface hslp_out_if;
  logic       valid;
  logic       ready;
  logic       reason_valid;
  logic [7:0] reason_byte;
  logic       done_res;
  logic [2:0] error_kind;
  logic [9:0] status_code;
  logic [3:0] version_major;
  logic [3:0] version_minor;

  modport source (
    output valid, output reason_valid, output reason_byte, output done_res,
    output error_kind, output status_code, output version_major,
    output version_minor, input ready
  );
  modport sink (
    input valid, input reason_valid, input reason_byte, input done_res,
    input error_kind, input status_code, input version_major,
    input version_minor, output ready
  );
endinterface

// ===== src/hslp_in_stage.sv =====
// Input register of the status line parser.
// Depends on hslp_pkg and hslp_in_if.
module hslp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  hslp_in_if.sink           in_ch,
  input  logic              advance,
  output logic              item_valid,
  output hslp_pkg::in_item_t item
);
  import hslp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // The register frees up whenever its item moves on into the result register.
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // Payload is captured on every input transfer.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{line_byte: in_ch.line_byte, line_end: in_ch.line_end};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// ===== src/hslp_parse_core.sv =====
// Per-line parse state and the combinational result of one byte.
// Depends on hslp_pkg and the assertion macros header.
`include "http_status_line_parser_top_defines.svh"
module hslp_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  hslp_pkg::in_item_t  item,
  output hslp_pkg::result_t   res
);
  import hslp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] version_pos_r, version_pos_nxt;
  logic       version_good_r, version_good_nxt;
  logic [3:0] major_digit_r, major_digit_nxt;
  logic [3:0] minor_digit_r, minor_digit_nxt;
  logic [2:0] code_digits_r, code_digits_nxt;
  logic [9:0] code_value_r, code_value_nxt;
  logic       code_good_r, code_good_nxt;
  logic       control_seen_r, control_seen_nxt;

  logic [7:0] ch;
  logic [3:0] digit;
  logic       vok;
  logic       cok;
  logic [2:0] err;

  assign ch    = item.line_byte;
  assign digit = 4'(ch - CH_ZERO);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt        = phase_r;
    version_pos_nxt  = version_pos_r;
    version_good_nxt = version_good_r;
    major_digit_nxt  = major_digit_r;
    minor_digit_nxt  = minor_digit_r;
    code_digits_nxt  = code_digits_r;
    code_value_nxt   = code_value_r;
    code_good_nxt    = code_good_r;
    control_seen_nxt = control_seen_r;
    res              = '0;
    vok              = 1'b0;
    cok              = 1'b0;
    err              = ERR_OK;

    if (ch == CH_NUL || ch == CH_LF || ch == CH_CR) begin
      control_seen_nxt = 1'b1;
    end

    case (phase_r)
      PH_VERSION: begin
        if (ch == CH_SPACE) begin
          phase_nxt = PH_CODE;
        end else begin
          if (version_pos_r < VER_PREFIX_LEN) begin
            if (ch != ver_prefix(version_pos_r[2:0])) version_good_nxt = 1'b0;
          end else if (version_pos_r == 4'd5) begin
            if (is_digit(ch)) major_digit_nxt = digit;
            else version_good_nxt = 1'b0;
          end else if (version_pos_r == 4'd6) begin
            if (ch != CH_DOT) version_good_nxt = 1'b0;
          end else if (version_pos_r == 4'd7) begin
            if (is_digit(ch)) minor_digit_nxt = digit;
            else version_good_nxt = 1'b0;
          end else begin
            version_good_nxt = 1'b0;
          end
          if (version_pos_r != VER_POS_MAX) version_pos_nxt = version_pos_r + 4'd1;
        end
      end
      PH_CODE: begin
        if (ch == CH_SPACE) begin
          phase_nxt = PH_REASON;
        end else begin
          if (is_digit(ch)) begin
            // Times ten as two shifts; the first three digits never exceed 999.
            if (code_digits_r < CODE_LEN) begin
              code_value_nxt = (code_value_r << 3) + (code_value_r << 1) + 10'(digit);
            end
          end else begin
            code_good_nxt = 1'b0;
          end
          if (code_digits_r != CODE_CNT_MAX) code_digits_nxt = code_digits_r + 3'd1;
        end
      end
      default: begin
        res.reason_valid = 1'b1;
        res.reason_byte  = ch;
      end
    endcase

    // Final byte: report and return to the start-of-line state.
    if (item.line_end) begin
      vok = version_good_nxt && (version_pos_nxt == VER_LEN);
      cok = code_good_nxt && (code_digits_nxt == CODE_LEN);
      if (control_seen_nxt) err = ERR_CONTROL;
      else if (phase_nxt == PH_VERSION) err = ERR_NOSPACE;
      else if (!vok) err = ERR_VERSION;
      else if (!cok) err = ERR_CODE;
      else err = ERR_OK;

      res.done_res   = 1'b1;
      res.error_kind = err;
      if (err == ERR_OK) res.status_code = code_value_nxt;
      if (err == ERR_OK || err == ERR_CODE) begin
        res.version_major = major_digit_nxt;
        res.version_minor = minor_digit_nxt;
      end

      phase_nxt        = PH_VERSION;
      version_pos_nxt  = '0;
      version_good_nxt = 1'b1;
      major_digit_nxt  = '0;
      minor_digit_nxt  = '0;
      code_digits_nxt  = '0;
      code_value_nxt   = '0;
      code_good_nxt    = 1'b1;
      control_seen_nxt = 1'b0;
    end
  end

  // State advances once per byte transfer into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_VERSION;
      version_pos_r  <= '0;
      version_good_r <= 1'b1;
      major_digit_r  <= '0;
      minor_digit_r  <= '0;
      code_digits_r  <= '0;
      code_value_r   <= '0;
      code_good_r    <= 1'b1;
      control_seen_r <= 1'b0;
    end else if (load) begin
      phase_r        <= phase_nxt;
      version_pos_r  <= version_pos_nxt;
      version_good_r <= version_good_nxt;
      major_digit_r  <= major_digit_nxt;
      minor_digit_r  <= minor_digit_nxt;
      code_digits_r  <= code_digits_nxt;
      code_value_r   <= code_value_nxt;
      code_good_r    <= code_good_nxt;
      control_seen_r <= control_seen_nxt;
    end
  end

  `HSLP_ASSERT_NEXT(a_line_end_clears, load && item.line_end, phase_r == PH_VERSION && version_pos_r == 4'd0 && code_digits_r == 3'd0 && !control_seen_r, "state not cleared after final byte")
  `HSLP_ASSERT_NEXT(a_reason_sticks, load && !item.line_end && phase_r == PH_REASON, phase_r == PH_REASON, "left reason phase before line end")
  `HSLP_ASSERT_NOW(a_quiet_mid_line, !item.line_end, res.error_kind == ERR_OK && res.status_code == 10'd0, "report fields set before final byte")
  `HSLP_ASSERT_NOW(a_code_range, 1'b1, code_value_r <= 10'd999, "code value out of range")
endmodule

// ===== src/hslp_out_stage.sv =====
// Result register of the status line parser, driving the result channel.
// Depends on hslp_pkg and hslp_out_if.
module hslp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  hslp_pkg::result_t  res,
  output logic               advance,
  hslp_out_if.source         out_ch
);
  import hslp_pkg::*;

  logic    valid_r;
  result_t res_r;

  // A new result may enter when the register is empty or being drained.
  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.reason_valid  = res_r.reason_valid;
  assign out_ch.reason_byte   = res_r.reason_byte;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.error_kind    = res_r.error_kind;
  assign out_ch.status_code   = res_r.status_code;
  assign out_ch.version_major = res_r.version_major;
  assign out_ch.version_minor = res_r.version_minor;
endmodule

// ===== src/http_status_line_parser_top.sv =====
// HTTP status line parser: one byte per transfer in, one result per byte out.
// Bytes go from the input register through the parse stage into the result register.
// Throughput: one byte per cycle unless out_ch stalls, set by the single parse stage.
// The input register accepts when it is empty or when the result register takes its byte.
// Reset (rst_n low, synchronous) empties both registers and starts a new line.
// Depends on hslp_pkg, hslp_in_if, hslp_out_if and the three stage modules.
module http_status_line_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  hslp_in_if.sink     in_ch,
  hslp_out_if.source  out_ch
);
  import hslp_pkg::*;

  logic     advance;
  logic     item_valid;
  in_item_t item;
  result_t  res;

  hslp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parse state moves only when a byte transfers into the result register.
  hslp_parse_core u_parse_core (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (item_valid && advance),
    .item  (item),
    .res   (res)
  );

  hslp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_ch     (out_ch)
  );
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for http_status_line_parser_top: status lines are sent one byte
// per transfer; each result is checked against a byte-level line parser or a typed want.
// Depends on hslp_pkg, hslp_in_if, hslp_out_if and the parser RTL.
module tb_top;
  import hslp_pkg::*;

  localparam logic [39:0] VERSION_TAG = "HTTP/";
  localparam int BYTES_PER_PHASE = 483;

  // One byte to send, with an optional expectation written out by hand.
  typedef struct {
    in_item_t item;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hslp_in_if  in_ch ();
  hslp_out_if out_ch ();

  http_status_line_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Line parser state, cleared at reset and after each final byte.
  phase_t      line_phase;
  logic [3:0]  ver_count;
  logic        ver_ok;
  logic [3:0]  major_dig;
  logic [3:0]  minor_dig;
  logic [2:0]  code_count;
  logic [9:0]  code_acc;
  logic        code_ok;
  logic        ctrl_seen;

  stim_row_t   directed_rows[$];
  stim_row_t   presented_rows[$];
  result_t     results_due[$];
  logic [7:0]  line_bytes[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_sent = 0;
  int mismatches = 0;

  always #5 clk = ~clk;

  function automatic void clear_line();
    line_phase = PH_VERSION;
    ver_count  = '0;
    ver_ok     = 1'b1;
    major_dig  = '0;
    minor_dig  = '0;
    code_count = '0;
    code_acc   = '0;
    code_ok    = 1'b1;
    ctrl_seen  = 1'b0;
  endfunction

  // Advances the line parser by one byte and returns the result it produces.
  function automatic result_t parse_status_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    dig;
    logic    ver_fine;
    logic    code_fine;
    r = '0;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    if (b == CH_NUL || b == CH_LF || b == CH_CR) ctrl_seen = 1'b1;

    case (line_phase)
      PH_VERSION: begin
        if (b == CH_SPACE) begin
          line_phase = PH_CODE;
        end else begin
          if (ver_count < VER_PREFIX_LEN) begin
            if (b != VERSION_TAG[39 - 8 * ver_count -: 8]) ver_ok = 1'b0;
          end else if (ver_count == VER_PREFIX_LEN) begin
            if (dig) major_dig = 4'(b - CH_ZERO);
            else ver_ok = 1'b0;
          end else if (ver_count == VER_PREFIX_LEN + 4'd1) begin
            if (b != CH_DOT) ver_ok = 1'b0;
          end else if (ver_count == VER_PREFIX_LEN + 4'd2) begin
            if (dig) minor_dig = 4'(b - CH_ZERO);
            else ver_ok = 1'b0;
          end else begin
            ver_ok = 1'b0;
          end
          if (ver_count != VER_POS_MAX) ver_count = ver_count + 4'd1;
        end
      end
      PH_CODE: begin
        if (b == CH_SPACE) begin
          line_phase = PH_REASON;
        end else begin
          if (!dig) code_ok = 1'b0;
          else if (code_count < CODE_LEN) code_acc = code_acc * 10'd10 + 10'(b - CH_ZERO);
          if (code_count != CODE_CNT_MAX) code_count = code_count + 3'd1;
        end
      end
      default: begin
        r.reason_valid = 1'b1;
        r.reason_byte  = b;
      end
    endcase

    // On the final byte, report with control bytes taking priority over all else.
    if (last) begin
      ver_fine  = ver_ok && (ver_count == VER_LEN);
      code_fine = code_ok && (code_count == CODE_LEN);
      r.done_res = 1'b1;
      if (ctrl_seen) r.error_kind = ERR_CONTROL;
      else if (line_phase == PH_VERSION) r.error_kind = ERR_NOSPACE;
      else if (!ver_fine) r.error_kind = ERR_VERSION;
      else if (!code_fine) r.error_kind = ERR_CODE;
      else r.error_kind = ERR_OK;
      if (r.error_kind == ERR_OK) r.status_code = code_acc;
      if (r.error_kind == ERR_OK || r.error_kind == ERR_CODE) begin
        r.version_major = major_dig;
        r.version_minor = minor_dig;
      end
      clear_line();
    end
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("rv=%0b rb=%02h done=%0b err=%0d code=%0d ver=%0d.%0d",
                     r.reason_valid, r.reason_byte, r.done_res, r.error_kind,
                     r.status_code, r.version_major, r.version_minor);
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(2))
      0:       return CH_NUL;
      1:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void add_line_text(input string s, input bit typed, input result_t want);
    stim_row_t row;
    for (int i = 0; i < s.len(); i++) begin
      row.item.line_byte = s[i];
      row.item.line_end  = (i == s.len() - 1);
      row.typed          = typed && row.item.line_end;
      row.want           = want;
      directed_rows.push_back(row);
    end
  endfunction

  // Fills line_bytes with one random line: mostly well-formed, some broken or noise.
  function automatic void build_random_line();
    int kind;
    int ver_extra;
    int code_len;
    int pos;
    line_bytes.delete();
    kind = $urandom_range(99);

    // Pure noise with spaces and control bytes mixed in.
    if (kind >= 90) begin
      repeat ($urandom_range(16, 1)) begin
        case ($urandom_range(9))
          0:       line_bytes.push_back(CH_SPACE);
          1:       line_bytes.push_back(pick_control());
          default: line_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
      return;
    end

    // Overlong version token or a code of the wrong length.
    ver_extra = 0;
    code_len  = 3;
    if (kind >= 80) begin
      if ($urandom_range(1) == 1) begin
        ver_extra = $urandom_range(9, 1);
      end else begin
        code_len = $urandom_range(9);
        if (code_len == 3) code_len = 8;
      end
    end

    for (int i = 0; i < 5; i++) line_bytes.push_back(VERSION_TAG[39 - 8 * i -: 8]);
    line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
    line_bytes.push_back(CH_DOT);
    line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
    repeat (ver_extra) line_bytes.push_back(8'($urandom_range(126, 33)));
    line_bytes.push_back(CH_SPACE);
    repeat (code_len) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));

    // The line may stop in the code token, after the second space, or carry a reason.
    case ($urandom_range(9))
      0, 1: ;
      2:    line_bytes.push_back(CH_SPACE);
      default: begin
        line_bytes.push_back(CH_SPACE);
        repeat ($urandom_range(12, 1)) line_bytes.push_back(8'($urandom_range(255, 32)));
      end
    endcase

    // Break one byte of an otherwise well-formed line.
    if (kind >= 55 && kind < 80) begin
      pos = $urandom_range(line_bytes.size() - 1);
      case ($urandom_range(3))
        0: line_bytes[pos] = 8'($urandom_range(255));
        1: if (line_bytes.size() > 1) line_bytes.delete(pos);
        2: line_bytes.insert(pos, 8'($urandom_range(255)));
        default: line_bytes[pos] = pick_control();
      endcase
    end
  endfunction

  // Presents one byte, idling first at random, and returns once it is transferred.
  task automatic send_row(input stim_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.line_byte <= row.item.line_byte;
    in_ch.line_end  <= row.item.line_end;
    presented_rows.push_back(row);
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Result side stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    stim_row_t row;
    result_t   calc;
    result_t   got;
    result_t   want;
    string     bad;
    if (!rst_n) begin
      clear_line();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        calc = parse_status_byte(in_ch.line_byte, in_ch.line_end);
        row = presented_rows.pop_front();
        results_due.push_back(row.typed ? row.want : calc);
      end

      if (out_ch.valid && out_ch.ready) begin
        got.reason_valid  = out_ch.reason_valid;
        got.reason_byte   = out_ch.reason_byte;
        got.done_res      = out_ch.done_res;
        got.error_kind    = out_ch.error_kind;
        got.status_code   = out_ch.status_code;
        got.version_major = out_ch.version_major;
        got.version_minor = out_ch.version_minor;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: %s", $time, fmt_result(got));
        end else begin
          want = results_due.pop_front();
          bad = "";
          if (got.reason_valid !== want.reason_valid) bad = {bad, " reason_valid"};
          if (got.reason_byte !== want.reason_byte) bad = {bad, " reason_byte"};
          if (got.done_res !== want.done_res) bad = {bad, " done_res"};
          if (got.error_kind !== want.error_kind) bad = {bad, " error_kind"};
          if (got.status_code !== want.status_code) bad = {bad, " status_code"};
          if (got.version_major !== want.version_major) bad = {bad, " version_major"};
          if (got.version_minor !== want.version_minor) bad = {bad, " version_minor"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch in%s: expected %s, got %s", $time, bad,
                       fmt_result(want), fmt_result(got));
          end
        end
      end
    end
  end

  // Stimulus: directed lines, then three idling phases of random lines.
  initial begin
    result_t want;
    int      tx_pct[3];
    int      rx_pct[3];
    stim_row_t row;
    tx_pct = '{19, 75, 0};
    rx_pct = '{75, 19, 0};

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.line_byte = '0;
    in_ch.line_end  = 1'b0;
    out_ch.ready    = 1'b0;

    // Highest byte alone: the line ends inside the version token.
    want = '0;
    want.done_res   = 1'b1;
    want.error_kind = ERR_NOSPACE;
    row.item  = '{line_byte: 8'hff, line_end: 1'b1};
    row.typed = 1'b1;
    row.want  = want;
    directed_rows.push_back(row);

    // NUL alone: a control byte beats the missing space.
    want.error_kind = ERR_CONTROL;
    row.item = '{line_byte: CH_NUL, line_end: 1'b1};
    row.want = want;
    directed_rows.push_back(row);

    // Good version, then the line ends right after the first space.
    want = '0;
    want.done_res      = 1'b1;
    want.error_kind    = ERR_CODE;
    want.version_major = 4'd1;
    want.version_minor = 4'd0;
    add_line_text("HTTP/1.0 ", 1'b1, want);

    // Top digits everywhere and a CR streamed as part of the reason.
    want = '0;
    want.reason_valid = 1'b1;
    want.reason_byte  = CH_CR;
    want.done_res     = 1'b1;
    want.error_kind   = ERR_CONTROL;
    add_line_text("HTTP/9.9 999 \015", 1'b1, want);

    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      while (bytes_sent < BYTES_PER_PHASE * (ph + 1)) begin
        build_random_line();
        foreach (line_bytes[i]) begin
          row.item.line_byte = line_bytes[i];
          row.item.line_end  = (i == line_bytes.size() - 1);
          row.typed          = 1'b0;
          row.want           = '0;
          send_row(row);
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then keep clocking so that the pipeline can show any stray result.
    while (results_due.size() != 0 || presented_rows.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS http_status_line_parser_top");
    end else begin
      $display("FAIL http_status_line_parser_top");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("FAIL http_status_line_parser_top");
    $finish;
  end

endmodule
